### hdl/hcbp_pkg.sv
// shared types and constants of the huffman code bit packer
`default_nettype none

package hcbp_pkg;

    // request kinds carried in the input tuser
    typedef enum logic [1:0] {
        REQ_WRITE  = 2'd0,
        REQ_ENCODE = 2'd1,
        REQ_FLUSH  = 2'd2
    } t_req;

    localparam int WORD_BITS    = 32;
    localparam int LEN_BITS     = 6;
    localparam int SYM_BITS     = 8;
    localparam int TABLE_DEPTH  = 256;
    localparam int MAX_CODE_LEN = 32;
    // stored lengths saturate at the smaller of the code limit and the word width
    localparam int CODE_LEN_LIMIT = (MAX_CODE_LEN < WORD_BITS) ? MAX_CODE_LEN : WORD_BITS;

    localparam int QUEUE_DEPTH  = 4;

    localparam int IN_DATA_BITS  = 48;
    localparam int OUT_DATA_BITS = 16;

    // accumulator: up to seven pending bits plus one longest code, rounded up
    localparam int ACC_BITS = 40;

    // table entry, code word stored left aligned (first code bit in bit 31)
    typedef struct packed {
        logic [LEN_BITS-1:0]  len;
        logic [WORD_BITS-1:0] word;
    } t_tbl_entry;

    localparam int TBL_BITS = $bits(t_tbl_entry);

    // work item handed from the front to the back
    typedef struct packed {
        logic                 flush;
        logic [LEN_BITS-1:0]  len;
        logic [WORD_BITS-1:0] word;
    } t_q_entry;

endpackage

`default_nettype wire

### hdl/hcbp_ram.sv
// generic single write port ram with registered read
`default_nettype none

module hcbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

### hdl/hcbp_front.sv
// front end: accepts requests, keeps the code table, looks up codes
`default_nettype none

module hcbp_front (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    input  wire logic [hcbp_pkg::IN_DATA_BITS-1:0]   i_s_tdata,
    input  wire logic [1:0]                          i_s_tuser,
    output logic                                     o_q_push,
    output hcbp_pkg::t_q_entry                       o_q_entry,
    input  wire logic                                i_q_full
);

    hcbp_pkg::t_req                           req;
    logic [hcbp_pkg::SYM_BITS-1:0]            sym;
    logic [hcbp_pkg::WORD_BITS-1:0]           word_in;
    logic [hcbp_pkg::LEN_BITS-1:0]            len_in;
    logic [hcbp_pkg::LEN_BITS-1:0]            len_sat;
    logic [hcbp_pkg::LEN_BITS-1:0]            la_shift;
    hcbp_pkg::t_tbl_entry                     wr_entry;
    hcbp_pkg::t_tbl_entry                     rd_entry;
    logic [hcbp_pkg::TBL_BITS-1:0]            rd_data;
    logic                                     accept;
    logic                                     adv;
    logic                                     do_wr;
    logic                                     do_rd;

    logic [hcbp_pkg::TABLE_DEPTH-1:0]         r_tbl_vld;
    logic                                     r_s1_vld;
    logic                                     r_s1_flush;
    logic                                     r_s1_hit;

    assign req     = hcbp_pkg::t_req'(i_s_tuser);
    assign sym     = i_s_tdata[7:0];
    assign word_in = i_s_tdata[39:8];
    assign len_in  = i_s_tdata[45:40];

    assign adv        = !r_s1_vld || !i_q_full;
    assign o_s_tready = adv;
    assign accept     = i_s_tvalid && adv;
    assign do_wr      = accept && (req == hcbp_pkg::REQ_WRITE);
    assign do_rd      = accept && (req == hcbp_pkg::REQ_ENCODE);

    // saturate the length, then left align the code (drops bits above the length)
    always_comb begin
        if (len_in > hcbp_pkg::LEN_BITS'(hcbp_pkg::CODE_LEN_LIMIT)) begin
            len_sat = hcbp_pkg::LEN_BITS'(hcbp_pkg::CODE_LEN_LIMIT);
        end else begin
            len_sat = len_in;
        end
        la_shift      = hcbp_pkg::LEN_BITS'(hcbp_pkg::WORD_BITS) - len_sat;
        wr_entry.len  = len_sat;
        wr_entry.word = word_in << la_shift;
    end

    hcbp_ram #(
        .WIDTH (hcbp_pkg::TBL_BITS),
        .DEPTH (hcbp_pkg::TABLE_DEPTH)
    ) u_tbl (
        .i_clk     (i_clk),
        .i_wr_en   (do_wr),
        .i_wr_addr (sym),
        .i_wr_data (wr_entry),
        .i_rd_en   (do_rd),
        .i_rd_addr (sym),
        .o_rd_data (rd_data)
    );

    assign rd_entry = hcbp_pkg::t_tbl_entry'(rd_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tbl_vld  <= '0;
            r_s1_vld   <= 1'b0;
            r_s1_flush <= 1'b0;
            r_s1_hit   <= 1'b0;
        end else begin
            if (do_wr) begin
                r_tbl_vld[sym] <= 1'b1;
            end
            if (adv) begin
                r_s1_vld   <= accept && (req == hcbp_pkg::REQ_ENCODE ||
                                         req == hcbp_pkg::REQ_FLUSH);
                r_s1_flush <= (req == hcbp_pkg::REQ_FLUSH);
                r_s1_hit   <= r_tbl_vld[sym];
            end
        end
    end

    // symbols without a code are dropped here
    always_comb begin
        o_q_entry.flush = r_s1_flush;
        o_q_entry.len   = rd_entry.len;
        o_q_entry.word  = rd_entry.word;
        o_q_push        = r_s1_vld && !i_q_full &&
                          (r_s1_flush || (r_s1_hit && rd_entry.len != '0));
    end

    a_push_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_push |-> r_s1_vld && (r_s1_flush || r_s1_hit))
        else $error("push of an item without table entry");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && i_q_full |=> r_s1_vld && $stable(r_s1_flush))
        else $error("stalled lookup lost");

    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && i_q_full |-> !o_s_tready)
        else $error("ready while lookup stage blocked");

endmodule

`default_nettype wire

### hdl/hcbp_queue.sv
// small register queue between front and back
`default_nettype none

module hcbp_queue #(
    parameter int DEPTH = hcbp_pkg::QUEUE_DEPTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire hcbp_pkg::t_q_entry i_entry,
    output logic                    o_full,
    output logic                    o_valid,
    output hcbp_pkg::t_q_entry      o_entry,
    input  wire logic               i_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    hcbp_pkg::t_q_entry r_mem [DEPTH];
    logic [PW-1:0]      r_wr_ptr;
    logic [PW-1:0]      r_rd_ptr;
    logic [CW-1:0]      r_count;
    logic               do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count out of range");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !do_pop |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count missed a push");

endmodule

`default_nettype wire

### hdl/hcbp_back.sv
// back end: bit accumulator and byte emitter with output register
`default_nettype none

module hcbp_back (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_q_valid,
    input  wire hcbp_pkg::t_q_entry                   i_q_entry,
    output logic                                      o_q_pop,
    output logic                                      o_m_tvalid,
    input  wire logic                                 i_m_tready,
    output logic      [hcbp_pkg::OUT_DATA_BITS-1:0]   o_m_tdata,
    output logic                                      o_m_tlast
);

    localparam int AW = hcbp_pkg::ACC_BITS;

    // pending bits kept left aligned: bit 6 is the earliest
    logic [6:0]     r_pend;
    logic [2:0]     r_cnt;
    logic [AW-1:0]  r_sh;
    logic [2:0]     r_rem;
    logic           r_has;
    logic [2:0]     r_pad;
    logic           r_o_vld;
    logic [7:0]     r_o_byte;
    logic           r_o_has;
    logic [2:0]     r_o_pad;
    logic           r_o_last;

    logic           fire;
    logic           load;
    logic [AW-1:0]  sh;
    logic [5:0]     n;
    logic [2:0]     k;
    logic [6:0]     n_pend;
    logic [2:0]     n_cnt;
    logic [7:0]     fl_byte;
    logic           fl_has;
    logic [2:0]     fl_pad;

    assign fire    = (r_rem != '0) && (!r_o_vld || i_m_tready);
    assign load    = (r_rem == '0) || (r_rem == 3'd1 && fire);
    assign o_q_pop = load && i_q_valid;

    // merge the left aligned code below the pending bits
    always_comb begin
        sh = {r_pend, 33'b0} | ({i_q_entry.word, 8'b0} >> r_cnt);
        n  = {3'b0, r_cnt} + i_q_entry.len;
        k  = n[5:3];
        n_cnt = n[2:0];
        case (k)
            3'd0:    n_pend = sh[39:33];
            3'd1:    n_pend = sh[31:25];
            3'd2:    n_pend = sh[23:17];
            3'd3:    n_pend = sh[15:9];
            3'd4:    n_pend = sh[7:1];
            default: n_pend = '0;
        endcase
        fl_byte = {r_pend, 1'b0};
        fl_has  = (r_cnt != '0);
        fl_pad  = fl_has ? 3'(4'd8 - {1'b0, r_cnt}) : 3'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= '0;
            r_cnt   <= '0;
            r_rem   <= '0;
            r_o_vld <= 1'b0;
        end else begin
            if (fire) begin
                r_o_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_o_vld <= 1'b0;
            end
            // a new item takes over the shifter as the last byte leaves
            if (o_q_pop) begin
                if (i_q_entry.flush) begin
                    r_sh   <= {fl_byte, 32'b0};
                    r_rem  <= 3'd1;
                    r_has  <= fl_has;
                    r_pad  <= fl_pad;
                    r_pend <= '0;
                    r_cnt  <= '0;
                end else begin
                    r_sh   <= sh;
                    r_rem  <= k;
                    r_has  <= 1'b1;
                    r_pad  <= '0;
                    r_pend <= n_pend;
                    r_cnt  <= n_cnt;
                end
            end else if (fire) begin
                r_sh  <= r_sh << 8;
                r_rem <= r_rem - 1'b1;
            end
        end
    end

    // output payload register
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_o_byte <= r_sh[AW-1 -: 8];
            r_o_has  <= r_has;
            r_o_pad  <= r_pad;
            r_o_last <= (r_rem == 3'd1);
        end
    end

    assign o_m_tvalid = r_o_vld;
    assign o_m_tdata  = {4'b0, r_o_pad, r_o_has, r_o_byte};
    assign o_m_tlast  = r_o_last;

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rem <= 3'd4)
        else $error("byte count out of range");

    a_pend_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == '0 |-> r_pend == '0)
        else $error("stray pending bits");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rem != '0 && r_o_vld && !i_m_tready |=> $stable(r_rem) && $stable(r_sh))
        else $error("emitter moved during output stall");

endmodule

`default_nettype wire

### hdl/huffman_code_bit_packer_top.sv
// top level of the huffman code bit packer
// usage
//   input stream: tuser carries the request kind (write table entry, encode,
//   flush); tdata carries symbol, code word and code length. a write stores
//   the symbol's code in a 256 entry table, an encode appends the symbol's
//   code bits to the pending byte, a flush emits the leftover bits.
//   output stream: one transfer per packed byte; tlast marks the last byte
//   caused by one request. a flush always gives exactly one transfer.
// path and throughput
//   a request is taken every cycle while the queue has room. an encode or
//   flush passes the table read at its input transfer, then the queue, the
//   merge and the output register before it shows up on the output.
//   the emitter sends one byte per cycle while the receiver takes them; a
//   request produces at most 4 bytes.
// reset
//   synchronous, active low; per-entry valid bits make the table read as empty,
//   pending byte, queue and output register are cleared, no clearing pass.
// stalls
//   when the receiver holds tready low the output register keeps its byte,
//   the emitter waits, the queue fills and then input tready falls.
`default_nettype none

module huffman_code_bit_packer_top #(
    parameter int QUEUE_DEPTH = hcbp_pkg::QUEUE_DEPTH
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_s_tvalid,
    output logic                                      o_s_tready,
    // symbol [7:0], code_word [39:8], code_length [45:40], zeros above
    input  wire logic [hcbp_pkg::IN_DATA_BITS-1:0]    i_s_tdata,
    // req_type [1:0]
    input  wire logic [1:0]                           i_s_tuser,
    output logic                                      o_m_tvalid,
    input  wire logic                                 i_m_tready,
    // out_byte [7:0], has_byte [8], padding_bits [11:9], zeros above
    output logic      [hcbp_pkg::OUT_DATA_BITS-1:0]   o_m_tdata,
    output logic                                      o_m_tlast
);

    logic               q_push;
    logic               q_full;
    logic               q_valid;
    logic               q_pop;
    hcbp_pkg::t_q_entry q_in;
    hcbp_pkg::t_q_entry q_out;

    // request intake and table lookup
    hcbp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_q_push   (q_push),
        .o_q_entry  (q_in),
        .i_q_full   (q_full)
    );

    // decouples lookup from byte emission
    hcbp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_entry (q_out),
        .i_pop   (q_pop)
    );

    // bit packing and output register
    hcbp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_entry  (q_out),
        .o_q_pop    (q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

`default_nettype wire
